// ===== hw/rtl/mia_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mia_pkg
// Shared constants, types and Q16.16 helpers for the adjugate inverse core.
// ----------------------------------------------------------------------------
package mia_pkg;

  // matrix geometry
  localparam int MAX_DIM   = 8;
  localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int SIZE_W    = $clog2(MAX_DIM + 1);
  localparam int MAT_DEPTH = MAX_DIM * MAX_DIM;
  localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
  localparam int CNT_W     = $clog2(MAT_DEPTH + 1);
  localparam int GRID_AW   = 2 * IDX_W;
  localparam int WORK_AW   = GRID_AW + 1;

  // configuration register
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] SIZE_RESET = 4'd8;

  // fixed point
  localparam logic signed [31:0] ONE_Q   = 32'sd65536;
  localparam logic signed [31:0] Q_MAX   = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN   = 32'sh80000000;
  localparam int DIV_STEPS = 48;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // work memory halves
  localparam logic SEL_GRID = 1'b0;
  localparam logic SEL_COF  = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD, S_JOB_INIT, S_CP_RD, S_CP_WR,
    S_PV_RD, S_PV_CHK, S_SR_RD, S_SR_CHK,
    S_SW_RDA, S_SW_RDB, S_SW_WRA, S_SW_WRB,
    S_PV_MUL, S_PV_ACC,
    S_EL_RDX, S_EL_DIV, S_EL_WAIT, S_EL_RDA, S_EL_RDB, S_EL_MUL, S_EL_SUB,
    S_JOB_FIN, S_JOB_END,
    S_OUT_RD, S_OUT_DIV, S_OUT_WAIT, S_OUT_SEND
  } state_t;

  typedef struct packed {
    logic              start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic signed [31:0] quo;
  } div_rsp_t;

  // saturate a wide value to 32 bits
  function automatic logic signed [31:0] fx_sat64(input logic signed [63:0] v);
    if (v > 64'(Q_MAX)) return Q_MAX;
    else if (v < 64'(Q_MIN)) return Q_MIN;
    else return v[31:0];
  endfunction

  // floor of product over 2^16, saturated
  function automatic logic signed [31:0] fx_mulq(input logic signed [63:0] p);
    return fx_sat64(p >>> 16);
  endfunction

  function automatic logic signed [31:0] fx_neg(input logic signed [31:0] a);
    if (a == Q_MIN) return Q_MAX;
    else return -a;
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return fx_sat64(64'(a) - 64'(b));
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mia_ifs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mia channel interfaces
// Valid/ready channels for elements, results and the size register.
// ----------------------------------------------------------------------------
interface mia_in_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] element_value;
  logic              last_element;
  modport source (output valid, element_value, last_element, input ready);
  modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface mia_out_if;
  logic              valid;
  logic              ready;
  logic signed [31:0] inverse_value;
  logic signed [31:0] determinant_value;
  logic              singular;
  logic              last_result;
  modport source (output valid, inverse_value, determinant_value, singular, last_result,
                  input ready);
  modport sink   (input valid, inverse_value, determinant_value, singular, last_result,
                  output ready);
endinterface

interface mia_cfg_if;
  logic             valid;
  logic             ready;
  logic [3:0]       matrix_size;
  modport source (output valid, matrix_size, input ready);
  modport sink   (input valid, matrix_size, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/mia_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mia_div
// Radix-2 restoring divider: trunc(num*2^16/den), saturated to Q16.16.
// ----------------------------------------------------------------------------
module mia_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mia_pkg::div_req_t req,
  output mia_pkg::div_rsp_t rsp
);

  logic                         busy_r;
  logic                         done_r;
  logic [mia_pkg::DIV_CW-1:0]   cnt_r;
  logic [31:0]                  rem_r;
  logic [31:0]                  dmag_r;
  logic [mia_pkg::DIV_STEPS-1:0] q_r;
  logic                         neg_r;
  logic signed [31:0]           quo_r;

  logic [32:0]                  rem_sh;
  logic                         ge;
  logic [31:0]                  rem_nxt;
  logic [mia_pkg::DIV_STEPS-1:0] q_nxt;
  logic signed [31:0]           fin;
  logic [31:0]                  amag;
  logic [31:0]                  bmag;

  // operand magnitudes
  assign amag = req.num[31] ? (~req.num + 32'd1) : req.num;
  assign bmag = req.den[31] ? (~req.den + 32'd1) : req.den;

  // one quotient bit per cycle
  always_comb begin
    rem_sh = {rem_r, q_r[mia_pkg::DIV_STEPS-1]};
    ge     = (rem_sh >= {1'b0, dmag_r});
    rem_nxt = ge ? 32'(rem_sh - {1'b0, dmag_r}) : rem_sh[31:0];
    q_nxt  = {q_r[mia_pkg::DIV_STEPS-2:0], ge};
  end

  // sign and saturation of the final quotient
  always_comb begin
    if (neg_r) begin
      if (q_nxt > mia_pkg::DIV_STEPS'(33'h080000000)) fin = mia_pkg::Q_MIN;
      else fin = 32'(32'd0 - q_nxt[31:0]);
    end else begin
      if (q_nxt > mia_pkg::DIV_STEPS'(33'h07fffffff)) fin = mia_pkg::Q_MAX;
      else fin = q_nxt[31:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == mia_pkg::DIV_CW'(mia_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + mia_pkg::DIV_CW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      rem_r  <= '0;
      q_r    <= {amag, 16'd0};
      dmag_r <= bmag;
      neg_r  <= req.num[31] ^ req.den[31];
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      if (cnt_r == mia_pkg::DIV_CW'(mia_pkg::DIV_STEPS - 1)) quo_r <= fin;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule
`default_nettype wire

// ===== hw/rtl/matrix_inverse_by_adjugate_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_by_adjugate_core
// Q16.16 matrix inverse: determinant and cofactors by elimination, adjugate
// divided by determinant, streamed row-major.
// ----------------------------------------------------------------------------
//  port     dir  transfer carries
//  in_bus   in   element_value, last_element
//  out_bus  out  inverse_value, determinant_value, singular, last_result
//  cfg_bus  in   matrix_size (1..8, reset 8)
//
//  elements load one per cycle; the flagged element starts the run
//  each elimination update reads, multiplies and subtracts through the single
//  work memory read port, and each division runs in the shared divider; a run
//  takes roughly (n*n+1) determinant passes of O(k^3) such steps, then one
//  division per result; a singular matrix skips the cofactors and divisions
//  and emits zero results
//  input is stalled from the flagged element until the last result transfer
//  synchronous active-low reset; no memory clearing pass
module matrix_inverse_by_adjugate_core (
  input  logic         clk,
  input  logic         rst_n,
  mia_in_if.sink       in_bus,
  mia_out_if.source    out_bus,
  mia_cfg_if.sink      cfg_bus
);

  localparam int SW = mia_pkg::SIZE_W;

  mia_pkg::state_t state_r, state_nxt;

  logic [mia_pkg::CFG_W-1:0] cfg_size_r;
  logic [mia_pkg::CNT_W-1:0] cnt_r;
  logic [SW-1:0] n_r, k_r, i_r, r_r, u_r, p_r, ci_r, cj_r;
  logic          is_det_r, odd_r, sing_r;
  logic signed [31:0] d_r, piv_r, a_r, b_r, f_r, jres_r, det_r, out_val_r;
  logic signed [63:0] prod_r;

  // memories
  logic signed [31:0] mat_mem [mia_pkg::MAT_DEPTH];
  logic signed [31:0] work_mem [2**mia_pkg::WORK_AW];
  logic signed [31:0] mat_rdata_r, wk_rdata_r;
  logic [mia_pkg::MAT_AW-1:0]  mat_raddr;
  logic [mia_pkg::WORK_AW-1:0] wk_raddr, wk_waddr;
  logic signed [31:0]          wk_wdata;
  logic                        wk_we;

  mia_pkg::div_req_t div_req;
  mia_pkg::div_rsp_t div_rsp;

  logic in_fire, out_fire, cfg_fire;
  logic [SW-1:0] k_m1, n_m1, src_row, src_col, n_clamp;
  logic [2*SW-1:0] lin;
  logic signed [31:0] sub_val, cof_val;
  logic out_last;

  function automatic logic [mia_pkg::WORK_AW-1:0] wk_addr(input logic sel,
                                                          input logic [SW-1:0] row,
                                                          input logic [SW-1:0] col);
    return {sel, row[mia_pkg::IDX_W-1:0], col[mia_pkg::IDX_W-1:0]};
  endfunction

  mia_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_fire  = in_bus.valid && in_bus.ready;
  assign out_fire = out_bus.valid && out_bus.ready;
  assign cfg_fire = cfg_bus.valid && cfg_bus.ready;

  assign k_m1 = k_r - SW'(1);
  assign n_m1 = n_r - SW'(1);
  assign out_last = (ci_r == n_m1) && (cj_r == n_m1);

  // clamp of the size register
  always_comb begin
    if (cfg_size_r == '0) n_clamp = SW'(1);
    else if ({1'b0, cfg_size_r} > (mia_pkg::CFG_W + 1)'(mia_pkg::MAX_DIM))
      n_clamp = SW'(mia_pkg::MAX_DIM);
    else n_clamp = SW'(cfg_size_r);
  end

  // source element of the copy, skipping the minor's row and column
  assign src_row = r_r + SW'(!is_det_r && (r_r >= ci_r));
  assign src_col = u_r + SW'(!is_det_r && (u_r >= cj_r));
  assign lin = (2*SW)'(src_row) * (2*SW)'(n_r) + (2*SW)'(src_col);
  assign mat_raddr = lin[mia_pkg::MAT_AW-1:0];

  // row update and signed cofactor
  assign sub_val = mia_pkg::fx_sub(b_r, mia_pkg::fx_mulq(prod_r));
  assign cof_val = (ci_r[0] ^ cj_r[0]) ? mia_pkg::fx_neg(jres_r) : jres_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mia_pkg::S_LOAD:
        if (in_fire && in_bus.last_element) state_nxt = mia_pkg::S_JOB_INIT;
      mia_pkg::S_JOB_INIT:
        state_nxt = (!is_det_r && n_r == SW'(1)) ? mia_pkg::S_JOB_END : mia_pkg::S_CP_RD;
      mia_pkg::S_CP_RD:  state_nxt = mia_pkg::S_CP_WR;
      mia_pkg::S_CP_WR:
        state_nxt = (r_r == k_m1 && u_r == k_m1) ? mia_pkg::S_PV_RD : mia_pkg::S_CP_RD;
      mia_pkg::S_PV_RD:  state_nxt = mia_pkg::S_PV_CHK;
      mia_pkg::S_PV_CHK:
        if (wk_rdata_r != 32'sd0) state_nxt = mia_pkg::S_PV_MUL;
        else if (i_r == k_m1) state_nxt = mia_pkg::S_JOB_END;
        else state_nxt = mia_pkg::S_SR_RD;
      mia_pkg::S_SR_RD:  state_nxt = mia_pkg::S_SR_CHK;
      mia_pkg::S_SR_CHK:
        if (wk_rdata_r != 32'sd0) state_nxt = mia_pkg::S_SW_RDA;
        else if (r_r == k_m1) state_nxt = mia_pkg::S_JOB_END;
        else state_nxt = mia_pkg::S_SR_RD;
      mia_pkg::S_SW_RDA: state_nxt = mia_pkg::S_SW_RDB;
      mia_pkg::S_SW_RDB: state_nxt = mia_pkg::S_SW_WRA;
      mia_pkg::S_SW_WRA: state_nxt = mia_pkg::S_SW_WRB;
      mia_pkg::S_SW_WRB:
        state_nxt = (u_r == k_m1) ? mia_pkg::S_PV_RD : mia_pkg::S_SW_RDA;
      mia_pkg::S_PV_MUL: state_nxt = mia_pkg::S_PV_ACC;
      mia_pkg::S_PV_ACC:
        state_nxt = (i_r == k_m1) ? mia_pkg::S_JOB_FIN : mia_pkg::S_EL_RDX;
      mia_pkg::S_EL_RDX: state_nxt = mia_pkg::S_EL_DIV;
      mia_pkg::S_EL_DIV: state_nxt = mia_pkg::S_EL_WAIT;
      mia_pkg::S_EL_WAIT:
        if (div_rsp.done) state_nxt = mia_pkg::S_EL_RDA;
      mia_pkg::S_EL_RDA: state_nxt = mia_pkg::S_EL_RDB;
      mia_pkg::S_EL_RDB: state_nxt = mia_pkg::S_EL_MUL;
      mia_pkg::S_EL_MUL: state_nxt = mia_pkg::S_EL_SUB;
      mia_pkg::S_EL_SUB:
        if (u_r != k_m1) state_nxt = mia_pkg::S_EL_RDA;
        else if (r_r == k_m1) state_nxt = mia_pkg::S_PV_RD;
        else state_nxt = mia_pkg::S_EL_RDX;
      mia_pkg::S_JOB_FIN: state_nxt = mia_pkg::S_JOB_END;
      mia_pkg::S_JOB_END:
        if (is_det_r)
          state_nxt = (jres_r == 32'sd0) ? mia_pkg::S_OUT_RD : mia_pkg::S_JOB_INIT;
        else
          state_nxt = (ci_r == n_m1 && cj_r == n_m1) ? mia_pkg::S_OUT_RD
                                                     : mia_pkg::S_JOB_INIT;
      mia_pkg::S_OUT_RD:
        state_nxt = sing_r ? mia_pkg::S_OUT_SEND : mia_pkg::S_OUT_DIV;
      mia_pkg::S_OUT_DIV: state_nxt = mia_pkg::S_OUT_WAIT;
      mia_pkg::S_OUT_WAIT:
        if (div_rsp.done) state_nxt = mia_pkg::S_OUT_SEND;
      mia_pkg::S_OUT_SEND:
        if (out_fire) state_nxt = out_last ? mia_pkg::S_LOAD : mia_pkg::S_OUT_RD;
      default: state_nxt = mia_pkg::S_LOAD;
    endcase
  end

  // outputs: handshakes, memory ports, divider requests
  always_comb begin
    in_bus.ready  = 1'b0;
    out_bus.valid = 1'b0;
    wk_we    = 1'b0;
    wk_waddr = wk_addr(mia_pkg::SEL_GRID, r_r, u_r);
    wk_wdata = sub_val;
    wk_raddr = wk_addr(mia_pkg::SEL_GRID, i_r, i_r);
    div_req.start = 1'b0;
    div_req.num   = wk_rdata_r;
    div_req.den   = piv_r;
    case (state_r)
      mia_pkg::S_LOAD:   in_bus.ready = 1'b1;
      mia_pkg::S_CP_WR: begin
        wk_we    = 1'b1;
        wk_wdata = mat_rdata_r;
      end
      mia_pkg::S_SR_RD:  wk_raddr = wk_addr(mia_pkg::SEL_GRID, r_r, i_r);
      mia_pkg::S_SW_RDA: wk_raddr = wk_addr(mia_pkg::SEL_GRID, i_r, u_r);
      mia_pkg::S_SW_RDB: wk_raddr = wk_addr(mia_pkg::SEL_GRID, p_r, u_r);
      mia_pkg::S_SW_WRA: begin
        wk_we    = 1'b1;
        wk_waddr = wk_addr(mia_pkg::SEL_GRID, i_r, u_r);
        wk_wdata = wk_rdata_r;
      end
      mia_pkg::S_SW_WRB: begin
        wk_we    = 1'b1;
        wk_waddr = wk_addr(mia_pkg::SEL_GRID, p_r, u_r);
        wk_wdata = a_r;
      end
      mia_pkg::S_EL_RDX: wk_raddr = wk_addr(mia_pkg::SEL_GRID, r_r, i_r);
      mia_pkg::S_EL_DIV: div_req.start = 1'b1;
      mia_pkg::S_EL_RDA: wk_raddr = wk_addr(mia_pkg::SEL_GRID, i_r, u_r);
      mia_pkg::S_EL_RDB: wk_raddr = wk_addr(mia_pkg::SEL_GRID, r_r, u_r);
      mia_pkg::S_EL_SUB: wk_we = 1'b1;
      mia_pkg::S_JOB_END: begin
        wk_we    = !is_det_r;
        wk_waddr = wk_addr(mia_pkg::SEL_COF, ci_r, cj_r);
        wk_wdata = cof_val;
      end
      // adjugate: read the transposed cofactor
      mia_pkg::S_OUT_RD: wk_raddr = wk_addr(mia_pkg::SEL_COF, cj_r, ci_r);
      mia_pkg::S_OUT_DIV: begin
        div_req.start = 1'b1;
        div_req.den   = det_r;
      end
      mia_pkg::S_OUT_SEND: out_bus.valid = 1'b1;
      default: ;
    endcase
  end

  assign cfg_bus.ready             = 1'b1;
  assign out_bus.inverse_value     = out_val_r;
  assign out_bus.determinant_value = det_r;
  assign out_bus.singular          = sing_r;
  assign out_bus.last_result       = out_last;

  // memories with registered reads
  always_ff @(posedge clk) begin
    if (in_fire && cnt_r < mia_pkg::CNT_W'(mia_pkg::MAT_DEPTH))
      mat_mem[cnt_r[mia_pkg::MAT_AW-1:0]] <= in_bus.element_value;
    mat_rdata_r <= mat_mem[mat_raddr];
  end

  always_ff @(posedge clk) begin
    if (wk_we) work_mem[wk_waddr] <= wk_wdata;
    wk_rdata_r <= work_mem[wk_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= mia_pkg::S_LOAD;
      cfg_size_r <= mia_pkg::SIZE_RESET;
      cnt_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) cfg_size_r <= cfg_bus.matrix_size;
      if (in_fire) begin
        if (in_bus.last_element) cnt_r <= '0;
        else if (cnt_r < mia_pkg::CNT_W'(mia_pkg::MAT_DEPTH))
          cnt_r <= cnt_r + mia_pkg::CNT_W'(1);
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      mia_pkg::S_LOAD:
        if (in_fire && in_bus.last_element) begin
          n_r      <= n_clamp;
          is_det_r <= 1'b1;
          ci_r     <= '0;
          cj_r     <= '0;
        end
      mia_pkg::S_JOB_INIT: begin
        k_r    <= is_det_r ? n_r : n_m1;
        r_r    <= '0;
        u_r    <= '0;
        i_r    <= '0;
        odd_r  <= 1'b0;
        d_r    <= mia_pkg::ONE_Q;
        jres_r <= mia_pkg::ONE_Q;
      end
      mia_pkg::S_CP_WR:
        if (u_r == k_m1) begin
          u_r <= '0;
          r_r <= r_r + SW'(1);
        end else begin
          u_r <= u_r + SW'(1);
        end
      mia_pkg::S_PV_CHK:
        if (wk_rdata_r != 32'sd0) begin
          piv_r <= wk_rdata_r;
        end else begin
          r_r    <= i_r + SW'(1);
          jres_r <= 32'sd0;
        end
      // first nonzero row below the pivot
      mia_pkg::S_SR_CHK:
        if (wk_rdata_r != 32'sd0) begin
          p_r   <= r_r;
          u_r   <= i_r;
          odd_r <= !odd_r;
        end else begin
          r_r <= r_r + SW'(1);
        end
      mia_pkg::S_SW_RDB: a_r <= wk_rdata_r;
      mia_pkg::S_SW_WRB: u_r <= u_r + SW'(1);
      mia_pkg::S_PV_MUL: prod_r <= 64'(d_r) * 64'(piv_r);
      mia_pkg::S_PV_ACC: begin
        d_r <= mia_pkg::fx_mulq(prod_r);
        r_r <= i_r + SW'(1);
      end
      mia_pkg::S_EL_WAIT:
        if (div_rsp.done) begin
          f_r <= div_rsp.quo;
          u_r <= i_r;
        end
      mia_pkg::S_EL_RDB: a_r <= wk_rdata_r;
      mia_pkg::S_EL_MUL: begin
        prod_r <= 64'(a_r) * 64'(f_r);
        b_r    <= wk_rdata_r;
      end
      mia_pkg::S_EL_SUB:
        if (u_r != k_m1) u_r <= u_r + SW'(1);
        else if (r_r == k_m1) i_r <= i_r + SW'(1);
        else r_r <= r_r + SW'(1);
      mia_pkg::S_JOB_FIN: jres_r <= odd_r ? mia_pkg::fx_neg(d_r) : d_r;
      mia_pkg::S_JOB_END:
        if (is_det_r) begin
          det_r    <= jres_r;
          sing_r   <= (jres_r == 32'sd0);
          is_det_r <= 1'b0;
          ci_r     <= '0;
          cj_r     <= '0;
        end else if (cj_r == n_m1) begin
          cj_r <= '0;
          ci_r <= (ci_r == n_m1) ? '0 : ci_r + SW'(1);
        end else begin
          cj_r <= cj_r + SW'(1);
        end
      mia_pkg::S_OUT_RD:
        if (sing_r) out_val_r <= 32'sd0;
      mia_pkg::S_OUT_WAIT:
        if (div_rsp.done) out_val_r <= div_rsp.quo;
      mia_pkg::S_OUT_SEND:
        if (out_fire) begin
          if (cj_r == n_m1) begin
            cj_r <= '0;
            ci_r <= ci_r + SW'(1);
          end else begin
            cj_r <= cj_r + SW'(1);
          end
        end
      default: ;
    endcase
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_bus.ready && out_bus.valid))
    else $error("input accepted while a result is pending");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_load_no_work_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mia_pkg::S_LOAD) |-> !wk_we)
    else $error("work memory written during load");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_bus.valid && out_bus.singular) |->
      (out_bus.inverse_value == 32'sd0 && out_bus.determinant_value == 32'sd0))
    else $error("singular result with nonzero value");

endmodule
`default_nettype wire
